FILE: hdl/ntpd_pkg.sv
`timescale 1ns / 1ps

package ntpd_pkg;

  localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
  localparam logic [31:0] SECS_PER_MINUTE  = 32'd60;
  localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
  localparam logic [31:0] UNIX_TO_NTP      = 32'h83aa7e80;
  localparam logic [10:0] FIRST_YEAR       = 11'd1900;
  localparam logic [16:0] ZONE_RESET       = 17'd28800;

  localparam logic [1:0] REG_EPOCH_SELECT = 2'd0;
  localparam logic [1:0] REG_ZONE_OFFSET  = 2'd1;

  // A 32-bit count reaches no further than 2036, so 1900 is the only century
  // year in range that is not a leap year (2000 is a leap year).
  function automatic logic is_leap(input logic [10:0] year);
    return (year[1:0] == 2'd0) && (year != FIRST_YEAR);
  endfunction

  // Length of a month in seconds, month 1 is January.
  function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      4'd2:                     days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  days = 5'd30;
      default:                  days = 5'd31;
    endcase
    return 32'(days) * SECS_PER_DAY;
  endfunction

endpackage

FILE: hdl/ntp_seconds_to_date.sv
`timescale 1ns / 1ps
// The year loop removes one elapsed year per step and the month loop one whole month per step,
// and day, hour and minute come from 16 restoring quotient steps, all on one subtractor.
// Throughput: one word at a time; in_tready is low while a conversion runs.
// Reset (rst_n low, synchronous) sets epoch select to 1900, the zone offset to +28800 s,
// and empties the sequencer and the output register.

module ntp_seconds_to_date (
  input  logic        clk,
  input  logic        rst_n,
  // Input word: [31:0] seconds_count.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // Result word: [10:0] year_value, [14:11] month_value, [19:15] day_value,
  // [24:20] hour_value, [30:25] minute_value, [36:31] second_value, [39:37] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // Configuration writes: index 0 is epoch_select, index 1 is zone_offset_seconds.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  import ntpd_pkg::*;

  // The conversion walks through phases. First the zone offset is added, then
  // whole years are removed one per cycle, then whole months, and finally the
  // day, hour and minute quotients are built one bit per cycle by restoring
  // division against the shifted period length.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ZONE,
    S_YEAR,
    S_MONTH,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_DAY,
    P_HOUR,
    P_MINUTE
  } phase_t;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic        epoch_r;
  logic [16:0] zone_r;
  logic [31:0] t_r, t_nxt;
  logic [10:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  quot_r, quot_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  logic        leap;
  logic [31:0] div_base;
  logic [31:0] sub_b;
  logic        covers;
  logic [31:0] difference;
  logic [5:0]  quot_step;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign leap = is_leap(year_r);

  always_comb begin
    case (phase_r)
      P_HOUR:   div_base = SECS_PER_HOUR;
      P_MINUTE: div_base = SECS_PER_MINUTE;
      default:  div_base = SECS_PER_DAY;
    endcase
  end

  // Operand for the shared subtractor, chosen by the current phase.
  always_comb begin
    case (state_r)
      S_YEAR:  sub_b = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
      S_MONTH: sub_b = month_secs(month_r, leap);
      S_DIV:   sub_b = div_base << bit_r;
      default: sub_b = '0;
    endcase
  end

  ntpd_sub_unit u_sub (
    .minuend    (t_r),
    .subtrahend (sub_b),
    .covers     (covers),
    .difference (difference)
  );

  assign quot_step = quot_r | (6'(covers) << bit_r);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    t_nxt      = t_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    quot_nxt   = quot_r;
    bit_nxt    = bit_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // A Unix count is moved onto the 1900 scale; the sum wraps.
          t_nxt     = in_tdata + (epoch_r ? UNIX_TO_NTP : 32'd0);
          year_nxt  = FIRST_YEAR;
          month_nxt = 4'd1;
          state_nxt = S_ZONE;
        end
      end
      S_ZONE: begin
        t_nxt     = t_r + {{15{zone_r[16]}}, zone_r};
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (covers) begin
          t_nxt    = difference;
          year_nxt = year_r + 11'd1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (covers && month_r != 4'd12) begin
          t_nxt     = difference;
          month_nxt = month_r + 4'd1;
        end else begin
          state_nxt = S_DIV;
          phase_nxt = P_DAY;
          quot_nxt  = '0;
          bit_nxt   = 3'd4;
        end
      end
      S_DIV: begin
        if (covers) begin
          t_nxt = difference;
        end
        quot_nxt = quot_step;
        bit_nxt  = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          quot_nxt = '0;
          case (phase_r)
            P_DAY: begin
              day_nxt   = quot_step[4:0] + 5'd1;
              phase_nxt = P_HOUR;
              bit_nxt   = 3'd4;
            end
            P_HOUR: begin
              hour_nxt  = quot_step[4:0];
              phase_nxt = P_MINUTE;
              bit_nxt   = 3'd5;
            end
            default: begin
              minute_nxt = quot_step;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_DAY;
      epoch_r     <= 1'b0;
      zone_r      <= ZONE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_EPOCH_SELECT) begin
          epoch_r <= cfg_data[0];
        end else if (cfg_index == REG_ZONE_OFFSET) begin
          zone_r <= cfg_data;
        end
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    quot_r   <= quot_nxt;
    bit_r    <= bit_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      // What is left of the remainder after the minute step is the second.
      out_data_r <= {3'd0, t_r[5:0], minute_r, hour_r, day_r, month_r, year_r};
    end
  end

endmodule

FILE: hdl/ntpd_sub_unit.sv
`timescale 1ns / 1ps

// Shared compare-and-subtract unit: tells whether the remainder covers the
// period length and gives the difference.
module ntpd_sub_unit (
  input  logic [31:0] minuend,
  input  logic [31:0] subtrahend,
  output logic        covers,
  output logic [31:0] difference
);

  logic [32:0] diff_wide;

  assign diff_wide  = {1'b0, minuend} - {1'b0, subtrahend};
  assign covers     = ~diff_wide[32];
  assign difference = diff_wide[31:0];

endmodule

FILE: hdl/ntpd_check.sv
`timescale 1ns / 1ps

module ntpd_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A held result word stays valid until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // The block takes one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a conversion runs");

  // Date fields stay inside the calendar.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:0] >= 11'd1900) && (out_tdata[10:0] <= 11'd2036) &&
                   (out_tdata[14:11] >= 4'd1) && (out_tdata[14:11] <= 4'd12) &&
                   (out_tdata[19:15] >= 5'd1))
    else $error("date field out of range");

  // Time-of-day fields stay inside their bounds.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[24:20] <= 5'd23) && (out_tdata[30:25] <= 6'd59) &&
                   (out_tdata[36:31] <= 6'd59) && (out_tdata[39:37] == 3'd0))
    else $error("time field out of range");

endmodule

bind ntp_seconds_to_date ntpd_check u_ntpd_check (.*);
